// ===== rtl/core/dpf_pkg.sv =====
// ----------------------------------------------------------------------------
// dpf_pkg
// Shared constants and types for the disparity plane fit pipeline.
// ----------------------------------------------------------------------------
package dpf_pkg;

   localparam int COORD_BITS_DEF     = 11;
   localparam int DISP_FRAC_BITS_DEF = 4;
   localparam int COEF_FRAC_BITS_DEF = 16;
   localparam int DISP_INT_BITS      = 8;
   localparam int COEF_BITS          = 32;
   localparam int QUOT_BITS          = 35;

   typedef struct packed {
      logic singular;
      logic neg_a;
      logic neg_b;
      logic neg_c;
   } side_type;

endpackage

// ===== rtl/core/dpf_div_lane.sv =====
// ----------------------------------------------------------------------------
// dpf_div_lane
// Pipelined restoring divider, one quotient bit per stage, with sticky
// overflow for quotient bits above the kept range.
// ----------------------------------------------------------------------------
module dpf_div_lane #(
   parameter int NUM_BITS = 40,
   parameter int DEN_BITS = 25,
   parameter int SHIFT    = 13
) (
   input  logic                           clock,
   input  logic                           en,
   input  logic [NUM_BITS-1:0]            num,
   input  logic [DEN_BITS-1:0]            den,
   output logic [dpf_pkg::QUOT_BITS-1:0]  quot,
   output logic                           ovf
);
   import dpf_pkg::*;

   localparam int DIVW = NUM_BITS + SHIFT;

   logic [DIVW-1:0]      dvd_ff [DIVW];
   logic [DEN_BITS-1:0]  rem_ff [DIVW];
   logic [DEN_BITS-1:0]  den_ff [DIVW];
   logic [QUOT_BITS-1:0] q_ff   [DIVW+1];
   logic                 ovf_ff [DIVW+1];

   assign dvd_ff[0] = {num, SHIFT'(0)};
   assign rem_ff[0] = '0;
   assign den_ff[0] = den;
   assign q_ff[0]   = '0;
   assign ovf_ff[0] = 1'b0;

   for (genvar i = 0; i < DIVW; i++) begin : g_stage
      logic [DEN_BITS:0] trial;
      logic [DEN_BITS:0] diff;
      logic              ge;

      always_comb begin
         trial = {rem_ff[i], dvd_ff[i][DIVW-1]};
         ge    = trial >= {1'b0, den_ff[i]};
         diff  = ge ? trial - {1'b0, den_ff[i]} : trial;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[i+1]   <= {q_ff[i][QUOT_BITS-2:0], ge};
            ovf_ff[i+1] <= ovf_ff[i] | q_ff[i][QUOT_BITS-1];
         end
      end

      if (i < DIVW - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               dvd_ff[i+1] <= {dvd_ff[i][DIVW-2:0], 1'b0};
               rem_ff[i+1] <= diff[DEN_BITS-1:0];
               den_ff[i+1] <= den_ff[i];
            end
         end
      end else begin : g_last
         logic unused_diff;
         assign unused_diff = ^diff;
      end
   end

   assign quot = q_ff[DIVW];
   assign ovf  = ovf_ff[DIVW];

endmodule

// ===== rtl/core/disparity_plane_fit.sv =====
// ----------------------------------------------------------------------------
// disparity_plane_fit
// Exact plane fit d = a*x + b*y + c through three triangle corners by
// Cramer's rule, with rounded, saturated Q15.16 coefficients.
// ----------------------------------------------------------------------------
// throughput: one beat per cycle while the skid register is empty; the divider lanes retire one bit per stage
// an output skid register lets the pipe take one more beat while rsp stalls
// reset clears valid bits only; no state survives between beats
// ----------------------------------------------------------------------------
module disparity_plane_fit #(
   parameter int COORD_BITS     = dpf_pkg::COORD_BITS_DEF,
   parameter int DISP_FRAC_BITS = dpf_pkg::DISP_FRAC_BITS_DEF,
   parameter int COEF_FRAC_BITS = dpf_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_valid,
   output logic                                          req_ready,
   input  logic [COORD_BITS-1:0]                         req_corner0_x,
   input  logic [COORD_BITS-1:0]                         req_corner0_y,
   input  logic [dpf_pkg::DISP_INT_BITS+DISP_FRAC_BITS-1:0] req_corner0_disp,
   input  logic [COORD_BITS-1:0]                         req_corner1_x,
   input  logic [COORD_BITS-1:0]                         req_corner1_y,
   input  logic [dpf_pkg::DISP_INT_BITS+DISP_FRAC_BITS-1:0] req_corner1_disp,
   input  logic [COORD_BITS-1:0]                         req_corner2_x,
   input  logic [COORD_BITS-1:0]                         req_corner2_y,
   input  logic [dpf_pkg::DISP_INT_BITS+DISP_FRAC_BITS-1:0] req_corner2_disp,
   output logic                                          rsp_valid,
   input  logic                                          rsp_ready,
   output logic signed [dpf_pkg::COEF_BITS-1:0]          rsp_slope_x,
   output logic signed [dpf_pkg::COEF_BITS-1:0]          rsp_slope_y,
   output logic signed [dpf_pkg::COEF_BITS-1:0]          rsp_offset,
   output logic                                          rsp_singular,
   output logic                                          rsp_saturated
);
   import dpf_pkg::*;

   localparam int CW    = COORD_BITS;
   localparam int DW    = DISP_INT_BITS + DISP_FRAC_BITS;
   localparam int PDW   = 2 * CW + 2;
   localparam int DETW  = 2 * CW + 3;
   localparam int PNW   = DW + CW + 2;
   localparam int NAW   = DW + CW + 3;
   localparam int M0W   = DW + 1 + DETW;
   localparam int MAW   = NAW + CW + 1;
   localparam int NCW   = ((M0W > MAW) ? M0W : MAW) + 2;
   localparam int SHIFT = COEF_FRAC_BITS - DISP_FRAC_BITS + 1;
   localparam int DIVW  = NCW + SHIFT;
   localparam int NST   = 7 + DIVW;

   function automatic logic [COEF_BITS:0] finish_coef(
      input logic [QUOT_BITS-1:0] q,
      input logic                 over,
      input logic                 neg
   );
      logic [QUOT_BITS:0]   rnd;
      logic [QUOT_BITS:0]   lim;
      logic                 sat;
      logic [COEF_BITS-1:0] mag;
      begin
         rnd = ({1'b0, q} + (QUOT_BITS+1)'(1)) >> 1;
         lim = neg ? (QUOT_BITS+1)'(64'h8000_0000) : (QUOT_BITS+1)'(64'h7FFF_FFFF);
         sat = over || (rnd > lim);
         mag = sat ? lim[COEF_BITS-1:0] : rnd[COEF_BITS-1:0];
         finish_coef = {sat, neg ? -mag : mag};
      end
   endfunction

   logic               en;
   logic [NST-1:0]     vld_ff;

   // stage 1: corner differences
   logic signed [CW:0] dx1_ff, dy1_ff, dx2_ff, dy2_ff;
   logic signed [DW:0] dd1_ff, dd2_ff;
   logic [CW-1:0]      x0_s1_ff, y0_s1_ff, x0_s2_ff, y0_s2_ff, x0_s3_ff, y0_s3_ff;
   logic [DW-1:0]      d0_s1_ff, d0_s2_ff, d0_s3_ff;
   // stage 2: cross products
   logic signed [PDW-1:0] p1_ff, p2_ff;
   logic signed [PNW-1:0] pa1_ff, pa2_ff, pb1_ff, pb2_ff;
   // stage 3..5: determinants
   logic signed [DETW-1:0] det_s3_ff, det_s4_ff, det_s5_ff;
   logic signed [NAW-1:0]  na_s3_ff, nb_s3_ff, na_s4_ff, nb_s4_ff, na_s5_ff, nb_s5_ff;
   logic signed [M0W-1:0]  m0_ff;
   logic signed [MAW-1:0]  ma_ff, mb_ff;
   logic signed [NCW-1:0]  nc_ff;
   // stage 6: magnitudes and signs
   logic signed [NCW-1:0]  na_w, nb_w;
   logic signed [DETW-1:0] det_neg;
   logic [NCW-1:0]         mag_a_ff, mag_b_ff, mag_c_ff;
   logic [DETW-1:0]        mag_d_ff;
   side_type               side_ff;
   side_type               side_pipe_ff [DIVW];

   logic [QUOT_BITS-1:0]   q_a, q_b, q_c;
   logic                   ovf_a, ovf_b, ovf_c;
   logic [COEF_BITS:0]     fin_a, fin_b, fin_c;

   logic signed [COEF_BITS-1:0] sx_ff, sy_ff, of_ff, sx_skid_ff, sy_skid_ff, of_skid_ff;
   logic                        sing_ff, sat_ff, sing_skid_ff, sat_skid_ff;
   logic                        skid_vld_ff;

   assign en        = !skid_vld_ff;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NST-2:0], req_valid};
      end
   end

   assign na_w    = NCW'(na_s5_ff);
   assign nb_w    = NCW'(nb_s5_ff);
   assign det_neg = -det_s5_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         dx1_ff   <= $signed({1'b0, req_corner1_x}) - $signed({1'b0, req_corner0_x});
         dy1_ff   <= $signed({1'b0, req_corner1_y}) - $signed({1'b0, req_corner0_y});
         dd1_ff   <= $signed({1'b0, req_corner1_disp}) - $signed({1'b0, req_corner0_disp});
         dx2_ff   <= $signed({1'b0, req_corner2_x}) - $signed({1'b0, req_corner0_x});
         dy2_ff   <= $signed({1'b0, req_corner2_y}) - $signed({1'b0, req_corner0_y});
         dd2_ff   <= $signed({1'b0, req_corner2_disp}) - $signed({1'b0, req_corner0_disp});
         x0_s1_ff <= req_corner0_x;
         y0_s1_ff <= req_corner0_y;
         d0_s1_ff <= req_corner0_disp;

         p1_ff    <= dx1_ff * dy2_ff;
         p2_ff    <= dx2_ff * dy1_ff;
         pa1_ff   <= dd1_ff * dy2_ff;
         pa2_ff   <= dd2_ff * dy1_ff;
         pb1_ff   <= dx1_ff * dd2_ff;
         pb2_ff   <= dx2_ff * dd1_ff;
         x0_s2_ff <= x0_s1_ff;
         y0_s2_ff <= y0_s1_ff;
         d0_s2_ff <= d0_s1_ff;

         det_s3_ff <= DETW'(p1_ff) - DETW'(p2_ff);
         na_s3_ff  <= NAW'(pa1_ff) - NAW'(pa2_ff);
         nb_s3_ff  <= NAW'(pb1_ff) - NAW'(pb2_ff);
         x0_s3_ff  <= x0_s2_ff;
         y0_s3_ff  <= y0_s2_ff;
         d0_s3_ff  <= d0_s2_ff;

         m0_ff     <= $signed({1'b0, d0_s3_ff}) * det_s3_ff;
         ma_ff     <= na_s3_ff * $signed({1'b0, x0_s3_ff});
         mb_ff     <= nb_s3_ff * $signed({1'b0, y0_s3_ff});
         det_s4_ff <= det_s3_ff;
         na_s4_ff  <= na_s3_ff;
         nb_s4_ff  <= nb_s3_ff;

         nc_ff     <= NCW'(m0_ff) - NCW'(ma_ff) - NCW'(mb_ff);
         det_s5_ff <= det_s4_ff;
         na_s5_ff  <= na_s4_ff;
         nb_s5_ff  <= nb_s4_ff;

         mag_a_ff         <= na_w[NCW-1] ? -na_w : na_w;
         mag_b_ff         <= nb_w[NCW-1] ? -nb_w : nb_w;
         mag_c_ff         <= nc_ff[NCW-1] ? -nc_ff : nc_ff;
         mag_d_ff         <= det_s5_ff[DETW-1] ? det_neg : det_s5_ff;
         side_ff.singular <= (det_s5_ff == '0);
         side_ff.neg_a    <= na_w[NCW-1] ^ det_s5_ff[DETW-1];
         side_ff.neg_b    <= nb_w[NCW-1] ^ det_s5_ff[DETW-1];
         side_ff.neg_c    <= nc_ff[NCW-1] ^ det_s5_ff[DETW-1];

         side_pipe_ff[0] <= side_ff;
         for (int k = 1; k < DIVW; k++) begin
            side_pipe_ff[k] <= side_pipe_ff[k-1];
         end
      end
   end

   dpf_div_lane #(.NUM_BITS(NCW), .DEN_BITS(DETW), .SHIFT(SHIFT)) u_div_a (
      .clock (clock), .en (en), .num (mag_a_ff), .den (mag_d_ff), .quot (q_a), .ovf (ovf_a)
   );
   dpf_div_lane #(.NUM_BITS(NCW), .DEN_BITS(DETW), .SHIFT(SHIFT)) u_div_b (
      .clock (clock), .en (en), .num (mag_b_ff), .den (mag_d_ff), .quot (q_b), .ovf (ovf_b)
   );
   dpf_div_lane #(.NUM_BITS(NCW), .DEN_BITS(DETW), .SHIFT(SHIFT)) u_div_c (
      .clock (clock), .en (en), .num (mag_c_ff), .den (mag_d_ff), .quot (q_c), .ovf (ovf_c)
   );

   assign fin_a = finish_coef(q_a, ovf_a, side_pipe_ff[DIVW-1].neg_a);
   assign fin_b = finish_coef(q_b, ovf_b, side_pipe_ff[DIVW-1].neg_b);
   assign fin_c = finish_coef(q_c, ovf_c, side_pipe_ff[DIVW-1].neg_c);

   // final stage: round, clip, apply sign; collinear corners force zeros
   always_ff @(posedge clock) begin
      if (en) begin
         if (side_pipe_ff[DIVW-1].singular) begin
            sx_ff  <= '0;
            sy_ff  <= '0;
            of_ff  <= '0;
            sat_ff <= 1'b0;
         end else begin
            sx_ff  <= fin_a[COEF_BITS-1:0];
            sy_ff  <= fin_b[COEF_BITS-1:0];
            of_ff  <= fin_c[COEF_BITS-1:0];
            sat_ff <= fin_a[COEF_BITS] | fin_b[COEF_BITS] | fin_c[COEF_BITS];
         end
         sing_ff <= side_pipe_ff[DIVW-1].singular;
      end
   end

   // skid register holds a result beat that was not taken
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         skid_vld_ff <= !rsp_ready;
      end else begin
         skid_vld_ff <= vld_ff[NST-1] && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_vld_ff) begin
         sx_skid_ff   <= sx_ff;
         sy_skid_ff   <= sy_ff;
         of_skid_ff   <= of_ff;
         sing_skid_ff <= sing_ff;
         sat_skid_ff  <= sat_ff;
      end
   end

   assign rsp_valid     = skid_vld_ff || vld_ff[NST-1];
   assign rsp_slope_x   = skid_vld_ff ? sx_skid_ff : sx_ff;
   assign rsp_slope_y   = skid_vld_ff ? sy_skid_ff : sy_ff;
   assign rsp_offset    = skid_vld_ff ? of_skid_ff : of_ff;
   assign rsp_singular  = skid_vld_ff ? sing_skid_ff : sing_ff;
   assign rsp_saturated = skid_vld_ff ? sat_skid_ff : sat_ff;

   a_skid_hold: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff && !rsp_ready |=> skid_vld_ff)
      else $error("skid beat dropped while stalled");

   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> rsp_slope_x == '0 && rsp_slope_y == '0 &&
                                    rsp_offset == '0 && !rsp_saturated)
      else $error("singular beat with nonzero coefficients");

   a_sat_clipped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         rsp_slope_x == 32'sh7FFF_FFFF || rsp_slope_x == 32'sh8000_0000 ||
         rsp_slope_y == 32'sh7FFF_FFFF || rsp_slope_y == 32'sh8000_0000 ||
         rsp_offset  == 32'sh7FFF_FFFF || rsp_offset  == 32'sh8000_0000)
      else $error("saturated flag without a clipped coefficient");

endmodule
